@@ rtl/aerp_pkg.sv @@
package aerp_pkg;

    localparam logic [7:0] RT_NONE       = 8'd0;
    localparam logic [7:0] RT_PC24       = 8'd1;
    localparam logic [7:0] RT_ABS32      = 8'd2;
    localparam logic [7:0] RT_REL32      = 8'd3;
    localparam logic [7:0] RT_THM_CALL   = 8'd10;
    localparam logic [7:0] RT_GLOB_DAT   = 8'd21;
    localparam logic [7:0] RT_JUMP_SLOT  = 8'd22;
    localparam logic [7:0] RT_RELATIVE   = 8'd23;
    localparam logic [7:0] RT_PLT32      = 8'd27;
    localparam logic [7:0] RT_CALL       = 8'd28;
    localparam logic [7:0] RT_JUMP24     = 8'd29;
    localparam logic [7:0] RT_THM_JUMP24 = 8'd30;
    localparam logic [7:0] RT_V4BX       = 8'd40;

    localparam logic CFG_LOAD_BASE = 1'b0;
    localparam logic CFG_LINK_BASE = 1'b1;

    localparam logic [31:0] V4BX_KEEP = 32'hf000000f;
    localparam logic [31:0] V4BX_SET  = 32'h01a0f000;
    localparam logic [15:0] THM_HI_KEEP = 16'hf800;
    localparam logic [15:0] THM_LO_KEEP = 16'hd000;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

@@ rtl/arm_elf_relocation_patch_core.sv @@
// ARM ELF32 relocation patcher. Each request on the slave stream is one relocation
// (type, link-time target address, symbol value, current word at the target); each
// request on the master stream carries the runtime target address, the patched word
// and a status (0 ok, 1 unsupported type, 2 Thumb branch not odd or out of range).
// One relocation is taken every clock unless the output is stalled; an input register and
// a result register hold it, with the branch arithmetic (S - P plus the re-based field, and
// the Thumb range check) between them. The user must write load_base and link_base through
// the config port only while the stream is idle; the block does not enforce this. A request
// accepted in any cycle after the write already sees the new bases.
module arm_elf_relocation_patch_core
    import aerp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] reloc_type, [39:8] target_offset, [71:40] symbol_value, [103:72] current_word
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] target_addr, [63:32] patched_word, [65:64] status, [71:66] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [31:0] r_load_base, r_link_base;

    logic        r_in_valid;
    logic [7:0]  r_type;
    logic [31:0] r_p, r_s, r_w;

    logic        r_out_valid;
    logic [31:0] r_out_addr, r_out_word;
    t_status     r_out_status;

    logic        out_ready, in_ready;
    logic [31:0] n_word;
    t_status     n_status;

    logic [31:0] sp, arm_t;
    logic [15:0] hi, lo;
    logic        sg, j1, j2;
    logic [31:0] thm_off, thm_sum;
    logic        thm_ok;
    logic        ns, nj1, nj2;
    logic [15:0] nh, nl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= '0;
            r_link_base <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_LOAD_BASE) begin
                r_load_base <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == CFG_LINK_BASE) begin
                r_link_base <= i_cfg_wdata;
            end
        end
    end

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_type <= s_axis_tdata[7:0];
            r_p    <= s_axis_tdata[39:8] + r_load_base - r_link_base;
            r_s    <= s_axis_tdata[71:40];
            r_w    <= s_axis_tdata[103:72];
        end
    end

    assign sp    = r_s - r_p;
    assign arm_t = sp + {{6{r_w[23]}}, r_w[23:0], 2'b00};

    assign hi = r_w[15:0];
    assign lo = r_w[31:16];
    assign sg = hi[10];
    assign j1 = lo[13];
    assign j2 = lo[11];
    assign thm_off = {{8{sg}}, ~(j1 ^ sg), ~(j2 ^ sg), hi[9:0], lo[10:0], 1'b0};
    assign thm_sum = thm_off + sp;
    // odd target and -2^24 < offset < 2^24
    assign thm_ok  = thm_sum[0] && ((thm_sum[31:24] == 8'h00) ||
                     (thm_sum[31:24] == 8'hff && thm_sum[23:0] != 24'd0));
    assign ns  = thm_sum[24];
    assign nj1 = ns ^ ~thm_sum[23];
    assign nj2 = ns ^ ~thm_sum[22];
    assign nh  = (hi & THM_HI_KEEP) | {5'd0, ns, thm_sum[21:12]};
    assign nl  = (lo & THM_LO_KEEP) | {2'b00, nj1, 1'b0, nj2, thm_sum[11:1]};

    always_comb begin
        n_word   = r_w;
        n_status = ST_OK;
        case (r_type) inside
            RT_NONE: begin
                n_word = r_w;
            end
            RT_ABS32, RT_RELATIVE: begin
                n_word = r_w + r_s;
            end
            RT_PC24, RT_PLT32, RT_CALL, RT_JUMP24: begin
                n_word = {r_w[31:24], arm_t[25:2]};
            end
            RT_REL32: begin
                n_word = r_w + sp;
            end
            RT_V4BX: begin
                n_word = (r_w & V4BX_KEEP) | V4BX_SET;
            end
            RT_GLOB_DAT, RT_JUMP_SLOT: begin
                n_word = r_s;
            end
            RT_THM_CALL, RT_THM_JUMP24: begin
                if (thm_ok) begin
                    n_word = {nl, nh};
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_UNSUP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out_addr   <= r_p;
            r_out_word   <= n_word;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_word, r_out_addr};

endmodule

@@ rtl/aerp_checker.sv @@
module aerp_checker
    import aerp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[65:64] == ST_OK ||
                           m_axis_tdata[65:64] == ST_UNSUP ||
                           m_axis_tdata[65:64] == ST_RANGE))
        else $error("undefined status code");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:66] == 6'd0)
        else $error("result padding not zero");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind arm_elf_relocation_patch_core aerp_checker u_aerp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/arm_elf_relocation_patch_core_tb.sv @@
`timescale 1ns / 1ps

module arm_elf_relocation_patch_core_tb;
    import aerp_pkg::*;

    // type numbers with no meaning to the patcher
    localparam logic [7:0] RT_GAP_LO = 8'd4;
    localparam logic [7:0] RT_GAP_HI = 8'd41;
    localparam logic [7:0] RT_TOP    = 8'd255;

    localparam int N_DIRECTED = 24;
    localparam int N_PHASES   = 5;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
        t_status     st;
    } t_patch_res;

    typedef struct packed {
        logic [7:0]  rt;
        logic [31:0] toff;
        logic [31:0] sym;
        logic [31:0] word;
        logic        typed;
        logic [31:0] exp_word;
        t_status     exp_st;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_addr;
    logic [31:0]            i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [7:0] reloc_type, [39:8] target_offset, [71:40] symbol_value, [103:72] current_word
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] target_addr, [63:32] patched_word, [65:64] status, [71:66] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [31:0] cfg_load = '0;
    logic [31:0] cfg_link = '0;
    t_patch_res  pending_patches[$];
    int          errors = 0;
    int          n_tx = 0;
    int          n_rx = 0;
    int          n_ok = 0;
    int          n_unsup = 0;
    int          n_range = 0;
    logic        tx_burst = 1'b0;

    logic [7:0] known_types [0:12] = '{
        RT_NONE, RT_PC24, RT_ABS32, RT_REL32, RT_THM_CALL, RT_GLOB_DAT, RT_JUMP_SLOT,
        RT_RELATIVE, RT_PLT32, RT_CALL, RT_JUMP24, RT_THM_JUMP24, RT_V4BX
    };

    // typed rows run with both bases at zero, so target_addr equals the offset
    t_dir_row dir_tab [0:N_DIRECTED-1] = '{
        '{RT_NONE,       32'h0,        32'h0,        32'h0,        1'b1, 32'h0,        ST_OK},
        '{RT_NONE,       32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff, ST_OK},
        '{RT_ABS32,      32'h00001000, 32'h00000001, 32'hffffffff, 1'b1, 32'h0,        ST_OK},
        '{RT_ABS32,      32'h0,        32'hffffffff, 32'hffffffff, 1'b1, 32'hfffffffe, ST_OK},
        '{RT_REL32,      32'h00008000, 32'h00010000, 32'h00000004, 1'b0, 32'h0,        ST_OK},
        '{RT_PC24,       32'h00008000, 32'h00010000, 32'heafffffe, 1'b0, 32'h0,        ST_OK},
        '{RT_PLT32,      32'h00010000, 32'h00008000, 32'heb7fffff, 1'b0, 32'h0,        ST_OK},
        '{RT_CALL,       32'hffffffff, 32'h0,        32'heb800000, 1'b0, 32'h0,        ST_OK},
        '{RT_JUMP24,     32'h0,        32'hffffffff, 32'hea000000, 1'b0, 32'h0,        ST_OK},
        '{RT_V4BX,       32'h0,        32'h0,        32'hffffffff, 1'b1, 32'hf1a0f00f, ST_OK},
        '{RT_V4BX,       32'h00000004, 32'h0,        32'h0,        1'b1, 32'h01a0f000, ST_OK},
        '{RT_GLOB_DAT,   32'h00000008, 32'hdeadbeef, 32'h12345678, 1'b1, 32'hdeadbeef, ST_OK},
        '{RT_JUMP_SLOT,  32'h0000000c, 32'hffffffff, 32'h0,        1'b1, 32'hffffffff, ST_OK},
        '{RT_RELATIVE,   32'h00000010, 32'h80000000, 32'h80000000, 1'b1, 32'h0,        ST_OK},
        '{RT_THM_CALL,   32'h00001000, 32'h00002001, 32'hf800f000, 1'b0, 32'h0,        ST_OK},
        // even target: no Thumb bit
        '{RT_THM_CALL,   32'h00001000, 32'h00002000, 32'hf800f000, 1'b1, 32'hf800f000,
          ST_RANGE},
        // range edges, both signs
        '{RT_THM_JUMP24, 32'h0,        32'h00ffffff, 32'hf800f000, 1'b0, 32'h0,        ST_OK},
        '{RT_THM_JUMP24, 32'h0,        32'h01000001, 32'hf800f000, 1'b1, 32'hf800f000,
          ST_RANGE},
        '{RT_THM_CALL,   32'h00ffffff, 32'h0,        32'hf800f000, 1'b0, 32'h0,        ST_OK},
        '{RT_THM_CALL,   32'h01000001, 32'h0,        32'hf800f000, 1'b1, 32'hf800f000,
          ST_RANGE},
        '{RT_THM_JUMP24, 32'h00002000, 32'h00001001, 32'hffffffff, 1'b0, 32'h0,        ST_OK},
        '{RT_GAP_LO,     32'h0,        32'h0,        32'ha5a5a5a5, 1'b1, 32'ha5a5a5a5, ST_UNSUP},
        '{RT_TOP,        32'hffffffff, 32'hffffffff, 32'h5a5a5a5a, 1'b1, 32'h5a5a5a5a, ST_UNSUP},
        '{RT_GAP_HI,     32'h00000020, 32'h0,        32'hffffffff, 1'b1, 32'hffffffff, ST_UNSUP}
    };

    arm_elf_relocation_patch_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_patch_res patch_reloc(input logic [7:0] rt, input logic [31:0] toff,
                                               input logic [31:0] sym, input logic [31:0] word);
        t_patch_res  r;
        logic [31:0] p;
        logic [31:0] fld;
        logic [31:0] t;
        logic [31:0] off;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] nh;
        logic [15:0] nl;
        logic        sg;
        p = cfg_load + toff - cfg_link;
        r.addr = p;
        r.word = word;
        r.st = ST_OK;
        case (rt)
            RT_NONE: ;
            RT_ABS32: r.word = word + sym;
            RT_REL32: r.word = word + (sym - p);
            RT_PC24, RT_PLT32, RT_CALL, RT_JUMP24: begin
                fld = {{8{word[23]}}, word[23:0]};
                t = sym - p + (fld << 2);
                r.word = {word[31:24], t[25:2]};
            end
            RT_V4BX: r.word = (word & V4BX_KEEP) | V4BX_SET;
            RT_GLOB_DAT, RT_JUMP_SLOT: r.word = sym;
            RT_RELATIVE: r.word = sym + word;
            RT_THM_CALL, RT_THM_JUMP24: begin
                hi = word[15:0];
                lo = word[31:16];
                sg = hi[10];
                off = {{7{sg}}, sg, ~(lo[13] ^ sg), ~(lo[11] ^ sg), hi[9:0], lo[10:0], 1'b0};
                off = off + (sym - p);
                if (!off[0] || $signed(off) <= -32'sd16777216 ||
                    $signed(off) >= 32'sd16777216) begin
                    r.st = ST_RANGE;
                end else begin
                    sg = off[24];
                    nh = (hi & THM_HI_KEEP) | {5'b0, sg, off[21:12]};
                    nl = (lo & THM_LO_KEEP) |
                         {2'b0, sg ^ ~off[23], 1'b0, sg ^ ~off[22], off[11:1]};
                    r.word = {nl, nh};
                end
            end
            default: r.st = ST_UNSUP;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic offer_reloc(input logic [7:0] rt, input logic [31:0] toff,
                               input logic [31:0] sym, input logic [31:0] word,
                               input t_patch_res want);
        int gap;
        if ($urandom_range(0, 19) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {word, sym, toff, rt};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        pending_patches.push_back(want);
        n_tx++;
    endtask

    // drop valid and wait until every pending request has come back
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_patches.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bases(input logic [31:0] load_val, input logic [31:0] link_val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_LOAD_BASE;
        i_cfg_wdata <= load_val;
        @(negedge i_clk);
        i_cfg_addr <= CFG_LINK_BASE;
        i_cfg_wdata <= link_val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (3) @(negedge i_clk);
        cfg_load = load_val;
        cfg_link = link_val;
    endtask

    task automatic random_relocs(input int n);
        logic [7:0]  rt;
        logic [31:0] toff;
        logic [31:0] sym;
        logic [31:0] word;
        logic [31:0] d;
        int          pick;
        for (int i = 0; i < n; i++) begin
            if (i == 30)
                settle();
            toff = pick32();
            sym = pick32();
            word = pick32();
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                rt = 8'($urandom_range(0, 255));
            end else if (pick < 7) begin
                rt = known_types[4'($urandom_range(0, 12))];
            end else begin
                // Thumb branch aimed near the patch site so the range check mostly passes
                rt = $urandom_range(0, 1) ? RT_THM_CALL : RT_THM_JUMP24;
                d = $urandom;
                d = {{9{d[22]}}, d[22:0]};
                if ($urandom_range(0, 7) != 0)
                    d[0] = 1'b1;
                sym = cfg_load + toff - cfg_link + d;
            end
            offer_reloc(rt, toff, sym, word, patch_reloc(rt, toff, sym, word));
        end
    endtask

    initial begin
        #2_000_000;
        $display("arm_elf_relocation_patch_core_tb: errors");
        $finish;
    end

    initial begin
        int         gap;
        logic       burst;
        t_patch_res want;
        burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 19) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 8);
            // long back-pressure so the core fills up and stalls its input
            if (n_rx == 100 || n_rx == 250)
                gap = 80;
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            n_rx++;
            if (pending_patches.size() == 0) begin
                $display("%0t: result with no request pending, got %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_patches.pop_front();
                check_field("target_addr", want.addr, m_axis_tdata[31:0]);
                check_field("patched_word", want.word, m_axis_tdata[63:32]);
                check_field("status", {30'b0, want.st}, {30'b0, m_axis_tdata[65:64]});
                check_field("pad", 32'h0, {26'b0, m_axis_tdata[71:66]});
                case (m_axis_tdata[65:64])
                    ST_OK:    n_ok++;
                    ST_UNSUP: n_unsup++;
                    default:  n_range++;
                endcase
            end
        end
    end

    initial begin
        t_dir_row    row;
        t_patch_res  want;
        logic [31:0] load_set [0:N_PHASES-1];
        logic [31:0] link_set [0:N_PHASES-1];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_LOAD_BASE;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        load_set[0] = 32'hffffffff;  link_set[0] = 32'h0;
        load_set[1] = 32'h0;         link_set[1] = 32'hffffffff;
        load_set[2] = 32'h80000000;  link_set[2] = 32'h7fffffff;
        load_set[3] = $urandom;      link_set[3] = $urandom;
        load_set[4] = $urandom;      link_set[4] = $urandom;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            row = dir_tab[k];
            if (row.typed)
                want = '{addr: row.toff, word: row.exp_word, st: row.exp_st};
            else
                want = patch_reloc(row.rt, row.toff, row.sym, row.word);
            offer_reloc(row.rt, row.toff, row.sym, row.word, want);
        end
        random_relocs(70);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            write_bases(load_set[ph], link_set[ph]);
            random_relocs(66);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d relocations (%0d directed) under %0d base settings incl. wrap extremes",
                 n_tx, N_DIRECTED, N_PHASES + 1);
        $display("Returned %0d: %0d ok, %0d unsupported type, %0d Thumb rejected",
                 n_rx, n_ok, n_unsup, n_range);
        if (errors == 0 && pending_patches.size() == 0) begin
            $display("arm_elf_relocation_patch_core_tb: clean");
        end else begin
            $display("arm_elf_relocation_patch_core_tb: errors");
        end
        $finish;
    end

endmodule
